FILE: sv/grid_bilinear_remap_clip_defines.svh
// ----------------------------------------------------------------------------
// grid_bilinear_remap_clip_defines.svh
// Assertion macros for the grid remap block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_REMAP_CLIP_DEFINES_SVH
`define GRID_BILINEAR_REMAP_CLIP_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while in reset
`define GBRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, also active during reset
`define GBRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBRC_ASSERT(label, prop, msg)
`define GBRC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: sv/gbrc_pkg.sv
// ----------------------------------------------------------------------------
// gbrc_pkg
// Shared constants, codes and payload types of the grid remap block.
// ----------------------------------------------------------------------------
package gbrc_pkg;

  // storage defaults
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int PT_W      = 23;                   // grid position width
  localparam int IA_W      = PT_W - FRAC_BITS;     // integer part of a position
  localparam int IDX_W     = IA_W + 1;             // column/row after origin add
  localparam int CRD_W     = 32;                   // node coordinate width
  localparam int WT_W      = FRAC_BITS + 3;        // weight, range [-1, 2]
  localparam int PR_W      = WT_W + CRD_W;         // weight * node
  localparam int RB_W      = PR_W + 1 - FRAC_BITS; // row blend, rounded
  localparam int BL_W      = WT_W + RB_W;          // weight * row blend
  localparam int BS_W      = BL_W + 1;             // sum of two such products
  localparam int CN_W      = BS_W - FRAC_BITS;     // column blend before clamp
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  // commands
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_MAP      = 2'd1;
  localparam logic [1:0] CMD_MAP_CLIP = 2'd2;
  localparam logic [1:0] CMD_NOP      = 2'd3;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CLIP = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_WIN_X1 = 3'd0;
  localparam logic [2:0] REG_WIN_X2 = 3'd1;
  localparam logic [2:0] REG_WIN_Y1 = 3'd2;
  localparam logic [2:0] REG_WIN_Y2 = 3'd3;
  localparam logic [2:0] REG_ORIGIN = 3'd4;
  localparam logic [2:0] REG_COLS   = 3'd5;
  localparam logic [2:0] REG_ROWS   = 3'd6;
  localparam logic [2:0] REG_SWAP   = 3'd7;

  localparam logic [13:0] ORIGIN_RST = 14'd8322;
  localparam logic [6:0]  COUNT_RST  = 7'd64;
  localparam logic signed [CRD_W-1:0] CLIP_VALUE = 32'sh7FFF_FFFF;
  localparam logic signed [CRD_W-1:0] NEG_LIMIT  = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]              command;
    logic [PT_W-1:0]         point_x;
    logic [PT_W-1:0]         point_y;
    logic [5:0]              node_col;
    logic [5:0]              node_row;
    logic signed [CRD_W-1:0] node_x;
    logic signed [CRD_W-1:0] node_y;
  } item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] out_x;
    logic signed [CRD_W-1:0] out_y;
    logic [1:0]              status;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] wdata;
  } cfg_t;

  // per-item side information carried down the blend pipeline
  typedef struct packed {
    logic                   oob;
    logic                   clip;
    logic signed [WT_W-1:0] wa0;
    logic signed [WT_W-1:0] wa1;
    logic signed [WT_W-1:0] wb0;
    logic signed [WT_W-1:0] wb1;
  } info_t;

endpackage

FILE: sv/gbrc_chan_if.sv
// ----------------------------------------------------------------------------
// gbrc_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface gbrc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/gbrc_ram.sv
// ----------------------------------------------------------------------------
// gbrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/grid_bilinear_remap_clip.sv
// ----------------------------------------------------------------------------
// grid_bilinear_remap_clip
// Bilinear remap of grid positions onto a loaded grid of node coordinates,
// with an optional window clip on the result.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | transfer
//  --------+-----+------------------------------------------------+-----------------
//  item    | in  | command, point_x/y, node_col/row, node_x/y     | valid && ready
//  result  | out | out_x, out_y, status                           | valid && ready
//  cfg     | in  | index, wdata                                   | valid (ready = 1)
//
//  A map item holds the read sequencer for four node reads through the
//  single read port of each coordinate store. A load makes one write to
//  both stores, and a command 3 is dropped on transfer.
//  Reset clears control and registers only; node stores are not cleared.
//  A result waiting in the output register freezes the pipeline; one more
//  item can still be taken into the staging register meanwhile.
//
`include "grid_bilinear_remap_clip_defines.svh"

module grid_bilinear_remap_clip
  import gbrc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input logic         clk,
  input logic         rst,
  gbrc_chan_if.sink   item,
  gbrc_chan_if.source result,
  gbrc_chan_if.sink   cfg
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [1:0] PH_LAST = 2'd3;

  // staging register: one decoded item waiting for / using the sequencer
  typedef struct packed {
    logic                    is_load;
    logic                    wr_ok;
    logic [AW-1:0]           waddr;
    logic signed [CRD_W-1:0] nx;
    logic signed [CRD_W-1:0] ny;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        c1;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        r1;
    info_t                   info;
  } stage_t;

  // ---------------------------------------------------------------- config
  logic signed [CRD_W-1:0] win_x1, win_x2, win_y1, win_y2;
  logic [13:0]             window_origin;
  logic [6:0]              grid_cols, grid_rows;
  logic                    swap_axes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x1        <= '0;
      win_x2        <= '0;
      win_y1        <= '0;
      win_y2        <= '0;
      window_origin <= ORIGIN_RST;
      grid_cols     <= COUNT_RST;
      grid_rows     <= COUNT_RST;
      swap_axes     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_WIN_X1: win_x1        <= cfg.data.wdata;
        REG_WIN_X2: win_x2        <= cfg.data.wdata;
        REG_WIN_Y1: win_y1        <= cfg.data.wdata;
        REG_WIN_Y2: win_y2        <= cfg.data.wdata;
        REG_ORIGIN: window_origin <= cfg.data.wdata[13:0];
        REG_COLS:   grid_cols     <= cfg.data.wdata[6:0];
        REG_ROWS:   grid_rows     <= cfg.data.wdata[6:0];
        REG_SWAP:   swap_axes     <= cfg.data.wdata[0];
        default:    swap_axes     <= swap_axes;
      endcase
    end
  end

  // -------------------------------------------------------- pipeline control
  logic       adv;      // whole pipeline moves; false only while result stalls
  logic       s0_valid;
  stage_t     s0, s0_next;
  logic [1:0] ph;       // read phase: bit 0 far column, bit 1 far row
  logic       s0_rel;
  logic       item_acc;

  assign adv        = !result.valid || result.ready;
  assign s0_rel     = adv && s0_valid && (s0.is_load || ph == PH_LAST);
  assign item.ready = !s0_valid || s0_rel;
  assign item_acc   = item.valid && item.ready;

  // --------------------------------------------------------- item decode
  // Axis split: integer part floored to at least 1, so the fraction is
  // negative for positions below 1.0. Weights are 1-f and f.
  localparam int FR_W_C = FRAC_BITS + 1;

  logic [PT_W-1:0]         pa, pb;
  logic [IA_W-1:0]         ia_a, ia_b;
  logic                    lo_a, lo_b;
  logic signed [FR_W_C-1:0] fa, fb;
  logic [6:0]              cols_eff, rows_eff;
  logic [IDX_W-1:0]        col_c, row_c;

  assign pa   = swap_axes ? item.data.point_y : item.data.point_x;
  assign pb   = swap_axes ? item.data.point_x : item.data.point_y;
  assign lo_a = (pa[PT_W-1:FRAC_BITS] == '0);
  assign lo_b = (pb[PT_W-1:FRAC_BITS] == '0);
  assign ia_a = lo_a ? IA_W'(1) : pa[PT_W-1:FRAC_BITS];
  assign ia_b = lo_b ? IA_W'(1) : pb[PT_W-1:FRAC_BITS];
  assign fa   = {lo_a, pa[FRAC_BITS-1:0]};
  assign fb   = {lo_b, pb[FRAC_BITS-1:0]};

  assign cols_eff = (int'(grid_cols) > MAX_COLS) ? 7'(MAX_COLS) : grid_cols;
  assign rows_eff = (int'(grid_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : grid_rows;
  assign col_c    = IDX_W'(ia_a) + IDX_W'(window_origin[6:0]) - IDX_W'(1);
  assign row_c    = IDX_W'(ia_b) + IDX_W'(window_origin[13:7]) - IDX_W'(1);

  always_comb begin
    s0_next         = '0;
    s0_next.is_load = (item.data.command == CMD_LOAD);
    s0_next.wr_ok   = (int'(item.data.node_col) < MAX_COLS) &&
                      (int'(item.data.node_row) < MAX_ROWS);
    s0_next.waddr   = AW'(int'(item.data.node_col) * MAX_ROWS +
                          int'(item.data.node_row));
    s0_next.nx      = item.data.node_x;
    s0_next.ny      = item.data.node_y;
    s0_next.col     = col_c;
    s0_next.row     = row_c;
    // far column/row clamps to the near one at the grid edge
    s0_next.c1      = ((col_c + IDX_W'(1)) < IDX_W'(cols_eff)) ? col_c + IDX_W'(1) : col_c;
    s0_next.r1      = ((row_c + IDX_W'(1)) < IDX_W'(rows_eff)) ? row_c + IDX_W'(1) : row_c;
    s0_next.info.oob  = (col_c >= IDX_W'(cols_eff)) || (row_c >= IDX_W'(rows_eff));
    s0_next.info.clip = (item.data.command == CMD_MAP_CLIP);
    s0_next.info.wa1  = WT_W'(fa);
    s0_next.info.wa0  = WT_W'(ONE) - WT_W'(fa);
    s0_next.info.wb1  = WT_W'(fb);
    s0_next.info.wb0  = WT_W'(ONE) - WT_W'(fb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      ph       <= '0;
    end else begin
      if (item_acc && item.data.command != CMD_NOP) begin
        s0_valid <= 1'b1;
      end else if (s0_rel) begin
        s0_valid <= 1'b0;
      end
      // wraps to zero on the last phase, together with the release
      if (adv && s0_valid && !s0.is_load) begin
        ph <= ph + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s0 <= s0_next;
    end
  end

  // ------------------------------------------------------------ node stores
  // Loads and reads both go through the staging register in order, so a
  // read never meets a write to the same entry in the same cycle.
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [IDX_W-1:0]        csel, rsel;
  logic signed [CRD_W-1:0] rd_x, rd_y;

  assign ram_we    = adv && s0_valid && s0.is_load && s0.wr_ok;
  assign ram_re    = adv && s0_valid && !s0.is_load;
  assign csel      = ph[0] ? s0.c1 : s0.col;
  assign rsel      = ph[1] ? s0.r1 : s0.row;
  assign ram_raddr = AW'(int'(csel) * MAX_ROWS + int'(rsel));

  gbrc_ram #(.WIDTH(CRD_W), .DEPTH(DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s0.waddr),
    .wdata (s0.nx),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_x)
  );

  gbrc_ram #(.WIDTH(CRD_W), .DEPTH(DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s0.waddr),
    .wdata (s0.ny),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_y)
  );

  // ------------------------------------------------------------- row blend
  // d: read data on the RAM outputs; p: weight * node; m: rounded rows.
  logic                   d_valid, p_valid, m_valid;
  logic [1:0]             d_ph, p_ph;
  info_t                  d_info, p_info, m_info;
  logic signed [WT_W-1:0] w_sel;
  logic signed [PR_W-1:0] prod_x, prod_y, acc_x, acc_y;
  logic signed [PR_W:0]   sum_x, sum_y;
  logic signed [RB_W-1:0] lo_x, lo_y, hi_x, hi_y;

  assign w_sel = d_ph[0] ? d_info.wa1 : d_info.wa0;
  // round half up: add half, floor by arithmetic shift
  assign sum_x = (PR_W+1)'(acc_x) + (PR_W+1)'(prod_x) + (PR_W+1)'(HALF);
  assign sum_y = (PR_W+1)'(acc_y) + (PR_W+1)'(prod_y) + (PR_W+1)'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= ram_re;
      p_valid <= d_valid;
      m_valid <= p_valid && (p_ph == PH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ph   <= ph;
      d_info <= s0.info;
      p_ph   <= d_ph;
      p_info <= d_info;
      prod_x <= w_sel * rd_x;
      prod_y <= w_sel * rd_y;
      if (p_valid) begin
        if (!p_ph[0]) begin
          acc_x <= prod_x;
          acc_y <= prod_y;
        end else if (!p_ph[1]) begin
          lo_x <= RB_W'(sum_x >>> FRAC_BITS);
          lo_y <= RB_W'(sum_y >>> FRAC_BITS);
        end else begin
          hi_x   <= RB_W'(sum_x >>> FRAC_BITS);
          hi_y   <= RB_W'(sum_y >>> FRAC_BITS);
          m_info <= p_info;
        end
      end
    end
  end

  // ---------------------------------------------------------- column blend
  logic                    b_valid, c_valid;
  info_t                   b_info, c_info;
  logic signed [BL_W-1:0]  bx0, bx1, by0, by1;
  logic signed [BS_W-1:0]  bsum_x, bsum_y;
  logic signed [CN_W-1:0]  cn_x, cn_y;
  logic signed [CRD_W-1:0] rx, ry;

  function automatic logic signed [CRD_W-1:0] clamp32(input logic signed [CN_W-1:0] v);
    logic [CN_W-CRD_W:0] top;
    top = v[CN_W-1:CRD_W-1];
    if (top == '0 || top == '1) begin
      return v[CRD_W-1:0];
    end
    return v[CN_W-1] ? NEG_LIMIT : CLIP_VALUE;
  endfunction

  assign bsum_x = BS_W'(bx0) + BS_W'(bx1) + BS_W'(HALF);
  assign bsum_y = BS_W'(by0) + BS_W'(by1) + BS_W'(HALF);
  assign cn_x   = CN_W'(bsum_x >>> FRAC_BITS);
  assign cn_y   = CN_W'(bsum_y >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= m_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_info <= m_info;
      bx0    <= m_info.wb0 * lo_x;
      bx1    <= m_info.wb1 * hi_x;
      by0    <= m_info.wb0 * lo_y;
      by1    <= m_info.wb1 * hi_y;
      c_info <= b_info;
      rx     <= clamp32(cn_x);
      ry     <= clamp32(cn_y);
    end
  end

  // ---------------------------------------------------- window and output
  function automatic logic out_of_window(input logic signed [CRD_W-1:0] v,
                                         input logic signed [CRD_W-1:0] a,
                                         input logic signed [CRD_W-1:0] b);
    if (a < b) begin
      return (v < a) || (v > b);
    end
    return (v > a) || (v < b);
  endfunction

  logic signed [CRD_W-1:0] ox, oy;
  result_t                 res_next;

  assign ox = swap_axes ? ry : rx;
  assign oy = swap_axes ? rx : ry;

  always_comb begin
    res_next.out_x  = ox;
    res_next.out_y  = oy;
    res_next.status = ST_OK;
    if (c_info.oob) begin
      res_next.out_x  = '0;
      res_next.out_y  = '0;
      res_next.status = ST_OUT;
    end else if (c_info.clip &&
                 (out_of_window(ox, win_x1, win_x2) || out_of_window(oy, win_y1, win_y2))) begin
      res_next.out_x  = CLIP_VALUE;
      res_next.status = ST_CLIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid) begin
      result.data <= res_next;
    end
  end

  // ------------------------------------------------------------ assertions
  `GBRC_ASSERT(a_phase_owner, (ph != 2'd0) |-> (s0_valid && !s0.is_load), "read phase without map item")
  `GBRC_ASSERT(a_stall_quiet, !adv |-> !(ram_re || ram_we), "store access during stall")
  `GBRC_ASSERT(a_row_done, (adv && p_valid && p_ph == PH_LAST) |=> m_valid, "row blend lost")
  `GBRC_ASSERT(a_no_rw_clash, !(ram_re && ram_we), "store read and write in one cycle")
  `GBRC_ASSERT_ALWAYS(a_reset_clear, rst |=> (!result.valid && ph == 2'd0), "reset left state")

endmodule

FILE: bench/tb_grid_bilinear_remap_clip.sv
// ----------------------------------------------------------------------------
// tb_grid_bilinear_remap_clip
// Self-checking bench for the grid remap block. Nodes are loaded and grid
// positions mapped through the item channel. Every map transfer is scored
// against a bilinear predictor kept alongside the block. Registers change
// only while the pipeline is empty. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_grid_bilinear_remap_clip;
  import gbrc_pkg::*;

  // lets the pipeline run dry after the last expected result
  localparam int DRAIN_CYCLES   = 16;
  // cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NODE_COUNT     = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam logic signed [CRD_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst;

  gbrc_chan_if #(.T(item_t))   item_if ();
  gbrc_chan_if #(.T(result_t)) result_if ();
  gbrc_chan_if #(.T(cfg_t))    cfg_if ();

  grid_bilinear_remap_clip i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: node coordinate stores and a shadow of every register.
  // node_loaded marks entries written so far; a map is never sent that would
  // read an entry still unwritten (its content is undefined in the block).
  // --------------------------------------------------------------------------
  logic signed [CRD_W-1:0] node_x_mem [NODE_COUNT];
  logic signed [CRD_W-1:0] node_y_mem [NODE_COUNT];
  bit                      node_loaded [NODE_COUNT];

  logic signed [CRD_W-1:0] cur_win_x1 = '0;
  logic signed [CRD_W-1:0] cur_win_x2 = '0;
  logic signed [CRD_W-1:0] cur_win_y1 = '0;
  logic signed [CRD_W-1:0] cur_win_y2 = '0;
  logic [13:0]             cur_origin = ORIGIN_RST;
  logic [6:0]              cur_cols   = COUNT_RST;
  logic [6:0]              cur_rows   = COUNT_RST;
  logic                    cur_swap   = 1'b0;

  // results predicted for accepted map items, oldest first
  result_t expected_coords [$];

  int  errors      = 0;
  int  gap_pct     = 20;  // chance of a sender gap before an item
  int  stall_pct   = 20;  // chance of a receiver stall burst per cycle
  bit  calm        = 1'b0;
  int  stall_left  = 0;
  int  idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Arithmetic of the remap
  // --------------------------------------------------------------------------

  // round half up to the node unit: add half, then floor
  function automatic longint round_node(input longint v);
    return (v + longint'(HALF)) >>> FRAC_BITS;
  endfunction

  function automatic longint sat_q16(input longint v);
    if (v > longint'(POS_LIMIT)) return longint'(POS_LIMIT);
    if (v < longint'(NEG_LIMIT)) return longint'(NEG_LIMIT);
    return v;
  endfunction

  // Splits a position into column/row and fractions under the current
  // registers. Returns 1 when the cell lies inside the used grid.
  function automatic bit locate_cell(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py,
                                     output int c0, output int c1,
                                     output int r0, output int r1,
                                     output longint fa, output longint fb);
    logic [PT_W-1:0] pa, pb;
    int ia, ib, cols, rows;
    pa = cur_swap ? py : px;
    pb = cur_swap ? px : py;
    // floor, raised to at least 1: a position below 1.0 gets a negative fraction
    ia = int'(pa >> FRAC_BITS);
    ib = int'(pb >> FRAC_BITS);
    if (ia < 1) ia = 1;
    if (ib < 1) ib = 1;
    fa = longint'(pa) - (longint'(ia) << FRAC_BITS);
    fb = longint'(pb) - (longint'(ib) << FRAC_BITS);
    c0 = ia + int'(cur_origin[6:0]) - 1;
    r0 = ib + int'(cur_origin[13:7]) - 1;
    // counts above the store size saturate
    cols = (cur_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cur_cols);
    rows = (cur_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(cur_rows);
    // far neighbor clamps to the near one at the grid edge
    c1 = (c0 < cols - 1) ? c0 + 1 : c0;
    r1 = (r0 < rows - 1) ? r0 + 1 : r0;
    return !(c0 > cols - 1 || r0 > rows - 1);
  endfunction

  // blend rows first, round, then blend the two rows, round, saturate
  function automatic longint blend_axis(input bit y_axis, input int c0, input int c1,
                                        input int r0, input int r1,
                                        input longint fa, input longint fb);
    longint one, n00, n10, n01, n11, lo, hi;
    one = longint'(ONE);
    if (y_axis) begin
      n00 = node_y_mem[c0 * MAX_ROWS_DEF + r0];
      n10 = node_y_mem[c1 * MAX_ROWS_DEF + r0];
      n01 = node_y_mem[c0 * MAX_ROWS_DEF + r1];
      n11 = node_y_mem[c1 * MAX_ROWS_DEF + r1];
    end else begin
      n00 = node_x_mem[c0 * MAX_ROWS_DEF + r0];
      n10 = node_x_mem[c1 * MAX_ROWS_DEF + r0];
      n01 = node_x_mem[c0 * MAX_ROWS_DEF + r1];
      n11 = node_x_mem[c1 * MAX_ROWS_DEF + r1];
    end
    lo = round_node((one - fa) * n00 + fa * n10);
    hi = round_node((one - fa) * n01 + fa * n11);
    return sat_q16(round_node((one - fb) * lo + fb * hi));
  endfunction

  // bounds may come in either order; equal bounds make a single point
  function automatic bit off_window(input longint v, input logic signed [CRD_W-1:0] b1,
                                    input logic signed [CRD_W-1:0] b2);
    longint a, b;
    a = b1;
    b = b2;
    if (a < b) return (v < a) || (v > b);
    return (v > a) || (v < b);
  endfunction

  function automatic result_t remap_point(input item_t it);
    result_t r;
    int c0, c1, r0, r1;
    longint fa, fb, ra, rb, ox, oy;
    r.status = ST_OK;
    if (!locate_cell(it.point_x, it.point_y, c0, c1, r0, r1, fa, fb)) begin
      // outside grid: zero result, no window test
      r.out_x  = '0;
      r.out_y  = '0;
      r.status = ST_OUT;
      return r;
    end
    ra = blend_axis(1'b0, c0, c1, r0, r1, fa, fb);
    rb = blend_axis(1'b1, c0, c1, r0, r1, fa, fb);
    ox = cur_swap ? rb : ra;
    oy = cur_swap ? ra : rb;
    if (it.command == CMD_MAP_CLIP &&
        (off_window(ox, cur_win_x1, cur_win_x2) || off_window(oy, cur_win_y1, cur_win_y2)))
    begin
      ox       = longint'(CLIP_VALUE);
      r.status = ST_CLIP;
    end
    r.out_x = ox[CRD_W-1:0];
    r.out_y = oy[CRD_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // random content for fields an item does not use
  function automatic item_t noise_item();
    item_t it;
    logic [31:0] a, b;
    a = $urandom;
    b = $urandom;
    it.command  = a[1:0];
    it.point_x  = a[24:2];
    it.point_y  = b[22:0];
    it.node_col = b[28:23];
    it.node_row = a[30:25];
    it.node_x   = $urandom;
    it.node_y   = $urandom;
    return it;
  endfunction

  // mostly small coordinates so windows matter, plus extremes and full range
  function automatic logic signed [CRD_W-1:0] rand_coord();
    int sel, v;
    sel = $urandom_range(0, 19);
    if (sel < 2) return POS_LIMIT;
    if (sel < 4) return NEG_LIMIT;
    if (sel < 14) begin
      v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      return v;
    end
    return $urandom;
  endfunction

  // Sends one item, with an optional sender gap first. Valid stays high on
  // return so a following item can go out in the next cycle; whoever stops
  // sending lowers it. The predictor is stepped on the accepting edge.
  task automatic push_item(input item_t it);
    int n;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      item_if.valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    item_if.data  <= it;
    item_if.valid <= 1'b1;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    case (it.command)
      CMD_LOAD: begin
        node_x_mem[it.node_col * MAX_ROWS_DEF + it.node_row]  = it.node_x;
        node_y_mem[it.node_col * MAX_ROWS_DEF + it.node_row]  = it.node_y;
        node_loaded[it.node_col * MAX_ROWS_DEF + it.node_row] = 1'b1;
      end
      CMD_MAP, CMD_MAP_CLIP: expected_coords.push_back(remap_point(it));
      default: ;  // command 3 is dropped by the block
    endcase
  endtask

  task automatic load_node(input int col, input int row,
                           input logic signed [CRD_W-1:0] x,
                           input logic signed [CRD_W-1:0] y);
    item_t it;
    logic [31:0] c, r;
    c = col;
    r = row;
    it          = noise_item();
    it.command  = CMD_LOAD;
    it.node_col = c[5:0];
    it.node_row = r[5:0];
    it.node_x   = x;
    it.node_y   = y;
    push_item(it);
  endtask

  // Sends a map item; any of the four neighbor nodes not yet loaded is
  // loaded first with random coordinates.
  task automatic map_point(input logic [1:0] cmd, input logic [PT_W-1:0] px,
                           input logic [PT_W-1:0] py);
    item_t it;
    int c0, c1, r0, r1;
    longint fa, fb;
    int cells [4];
    if (locate_cell(px, py, c0, c1, r0, r1, fa, fb)) begin
      cells = '{c0 * MAX_ROWS_DEF + r0, c1 * MAX_ROWS_DEF + r0,
                c0 * MAX_ROWS_DEF + r1, c1 * MAX_ROWS_DEF + r1};
      foreach (cells[k])
        if (!node_loaded[cells[k]])
          load_node(cells[k] / MAX_ROWS_DEF, cells[k] % MAX_ROWS_DEF,
                    rand_coord(), rand_coord());
    end
    it         = noise_item();
    it.command = cmd;
    it.point_x = px;
    it.point_y = py;
    push_item(it);
  endtask

  // Stops sending, waits for every expected result, then lets the pipeline
  // run dry: loads and dropped commands leave no result to wait for.
  task automatic drain_pipeline();
    item_if.valid <= 1'b0;
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high between back-to-back writes; apply_config lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_t c;
    c.index = idx;
    c.wdata = val;
    cfg_if.data  <= c;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_WIN_X1: cur_win_x1 = val;
      REG_WIN_X2: cur_win_x2 = val;
      REG_WIN_Y1: cur_win_y1 = val;
      REG_WIN_Y2: cur_win_y2 = val;
      REG_ORIGIN: cur_origin = val[13:0];
      REG_COLS:   cur_cols   = val[6:0];
      REG_ROWS:   cur_rows   = val[6:0];
      REG_SWAP:   cur_swap   = val[0];
      default: ;
    endcase
  endtask

  // Writes all eight registers once the block is idle. Narrow registers get
  // random junk above their width half the time; the block must drop it.
  task automatic apply_config(input logic [31:0] wx1, input logic [31:0] wx2,
                              input logic [31:0] wy1, input logic [31:0] wy2,
                              input logic [13:0] origin, input logic [6:0] cols,
                              input logic [6:0] rows, input logic swap);
    logic [31:0] junk;
    drain_pipeline();
    junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
    write_reg(REG_WIN_X1, wx1);
    write_reg(REG_WIN_X2, wx2);
    write_reg(REG_WIN_Y1, wy1);
    write_reg(REG_WIN_Y2, wy2);
    write_reg(REG_ORIGIN, {junk[31:14], origin});
    write_reg(REG_COLS, {junk[31:7], cols});
    write_reg(REG_ROWS, {junk[31:7], rows});
    write_reg(REG_SWAP, {junk[31:1], swap});
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at reset: row origin 65 puts every position outside the grid,
  // so maps give the outside status and no node is loaded for them.
  task automatic test_reset_state();
    item_t it;
    map_point(CMD_MAP, 23'h01_0000, 23'h01_0000);
    map_point(CMD_MAP_CLIP, 23'h00_0000, 23'h00_0000);
    it         = noise_item();
    it.command = CMD_NOP;
    push_item(it);
  endtask

  // 3x2 grid at origin 0 with extreme node values: exact nodes, midpoint,
  // edge clamp, positions below 1.0 (extrapolation up to saturation),
  // column and row just past the grid, largest position.
  task automatic test_grid_corners();
    apply_config(NEG_LIMIT, POS_LIMIT, POS_LIMIT, NEG_LIMIT, 14'd0, 7'd3, 7'd2, 1'b0);
    load_node(0, 0, POS_LIMIT, NEG_LIMIT);
    load_node(1, 0, NEG_LIMIT, POS_LIMIT);
    load_node(2, 0, 32'sd0, 32'sd0);
    load_node(0, 1, 32'sh0001_0000, -32'sh0001_0000);
    load_node(1, 1, 32'sh0002_0000, 32'sh0003_0000);
    load_node(2, 1, -32'sd1, 32'sd1);
    map_point(CMD_MAP, 23'h01_0000, 23'h01_0000);
    map_point(CMD_MAP_CLIP, 23'h01_8000, 23'h01_8000);
    map_point(CMD_MAP, 23'h03_0000, 23'h02_0000);
    map_point(CMD_MAP, 23'h03_C000, 23'h02_4000);
    map_point(CMD_MAP, 23'h00_0000, 23'h00_0000);
    map_point(CMD_MAP_CLIP, 23'h04_0000, 23'h01_0000);
    map_point(CMD_MAP, 23'h01_0000, 23'h03_0000);
    map_point(CMD_MAP_CLIP, 23'h7F_FFFF, 23'h7F_FFFF);
  endtask

  // Swapped axes with a column origin of 1, x window collapsed to 0.0 and
  // y window in reversed order; then zero columns with maximal origin.
  task automatic test_window_and_swap();
    apply_config(32'd0, 32'd0, POS_LIMIT, NEG_LIMIT, 14'd1, 7'd3, 7'd2, 1'b1);
    map_point(CMD_MAP_CLIP, 23'h01_0000, 23'h01_0000);  // clipped on x
    map_point(CMD_MAP_CLIP, 23'h01_0000, 23'h02_0000);  // lands on 0.0, passes
    map_point(CMD_MAP, 23'h01_4000, 23'h01_8000);
    map_point(CMD_MAP_CLIP, 23'h01_0000, 23'h03_0000);  // past last column
    apply_config($urandom, $urandom, $urandom, $urandom, 14'h3FFF, 7'd0, 7'd127, 1'b1);
    map_point(CMD_MAP_CLIP, 23'h00_0000, 23'h00_0000);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic int pick_origin();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, 2);
    if (sel < 9) return $urandom_range(0, 8);
    return $urandom_range(0, 127);
  endfunction

  function automatic int pick_count();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return $urandom_range(1, 8);
    if (sel < 16) return $urandom_range(1, 64);
    if (sel < 18) return $urandom_range(65, 127);
    if (sel < 19) return 0;
    return 64;
  endfunction

  // 1-based position aimed at a cell near the used grid, sometimes one
  // past it and sometimes below 1.0
  function automatic logic [PT_W-1:0] aim_axis(input int count, input int org);
    int eff, target, ip;
    logic [31:0] ipv, fr;
    eff    = (count > MAX_COLS_DEF) ? MAX_COLS_DEF : count;
    target = $urandom_range(0, eff);
    ip     = target - org + 1;
    if (ip < 1 || $urandom_range(0, 9) == 0) ip = $urandom_range(0, 1);
    if (ip > 127) ip = 127;
    ipv = ip;
    fr  = $urandom;
    return {ipv[6:0], fr[15:0]};
  endfunction

  // Phases of random traffic, each under fresh random registers. Most items
  // are maps aimed at the loaded grid; the rest are stray loads, dropped
  // commands and maps at arbitrary positions. The last phase runs without
  // any idling.
  task automatic test_random_traffic(input int phases, input int per_phase);
    int oc, orow, cols, rows, sel;
    logic [31:0] ocv, orv, cv, rv;
    logic [PT_W-1:0] pa, pb;
    logic [1:0] cmd;
    item_t it;
    for (int p = 0; p < phases; p++) begin
      calm      = (p == phases - 1);
      gap_pct   = calm ? 0 : pick_pct();
      stall_pct = calm ? 0 : pick_pct();
      oc   = pick_origin();
      orow = pick_origin();
      cols = pick_count();
      rows = pick_count();
      ocv = oc;
      orv = orow;
      cv  = cols;
      rv  = rows;
      apply_config(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   {orv[6:0], ocv[6:0]}, cv[6:0], rv[6:0], $urandom_range(0, 1) == 1);
      for (int k = 0; k < per_phase; k++) begin
        sel = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 1) == 1) ? CMD_MAP_CLIP : CMD_MAP;
        if (sel < 8) begin
          load_node($urandom_range(0, 63), $urandom_range(0, 63), rand_coord(), rand_coord());
        end else if (sel < 12) begin
          it         = noise_item();
          it.command = CMD_NOP;
          push_item(it);
        end else if (sel < 22) begin
          it = noise_item();
          map_point(cmd, it.point_x, it.point_y);
        end else begin
          pa = aim_axis(cols, oc);
          pb = aim_axis(rows, orow);
          // swapped mode takes the column axis from point_y
          if (cur_swap) map_point(cmd, pb, pa);
          else          map_point(cmd, pa, pb);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on ready, and scoring of each transfer
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  result_t want;

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_coords.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h %h %h", $time,
                 result_if.data.out_x, result_if.data.out_y, result_if.data.status);
      end else begin
        want = expected_coords.pop_front();
        if (result_if.data.out_x !== want.out_x) begin
          errors++;
          $display("%0t out_x mismatch: expected %h, actual %h", $time,
                   want.out_x, result_if.data.out_x);
        end
        if (result_if.data.out_y !== want.out_y) begin
          errors++;
          $display("%0t out_y mismatch: expected %h, actual %h", $time,
                   want.out_y, result_if.data.out_y);
        end
        if (result_if.data.status !== want.status) begin
          errors++;
          $display("%0t status mismatch: expected %0d, actual %0d", $time,
                   want.status, result_if.data.status);
        end
      end
    end
    // ready goes low in bursts of random length
    if (stall_left > 0)
      stall_left--;
    else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 4);
    result_if.ready <= (stall_left == 0);
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_bilinear_remap_clip regression: fail");
      $finish;
    end
  end

  initial begin
    rst             <= 1'b1;
    item_if.valid   <= 1'b0;
    item_if.data    <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_grid_corners();
    test_window_and_swap();
    test_random_traffic(13, 115);

    drain_pipeline();
    if (expected_coords.size() != 0) errors++;
    if (errors == 0) begin
      $display("grid_bilinear_remap_clip regression: pass");
    end else begin
      $display("grid_bilinear_remap_clip regression: fail");
    end
    $finish;
  end

endmodule

FILE: grid_bilinear_remap_clip.f
+incdir+sv
sv/gbrc_pkg.sv
sv/gbrc_chan_if.sv
sv/gbrc_ram.sv
sv/grid_bilinear_remap_clip.sv
bench/tb_grid_bilinear_remap_clip.sv
